// ----- rtl/kmv_pkg.sv -----
// shared types, constants and hash helpers for the kmv sketch builder
package kmv_pkg;

	localparam int unsigned CAPACITY_DEF = 512;
	localparam int unsigned PADDR_W      = 2;
	localparam logic [PADDR_W-1:0] REG_LIMIT_ADDR = 2'd0;
	localparam logic [9:0] LIMIT_RESET = 10'd512;

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_READ   = 2'd1;
	localparam logic [1:0] ACT_CLEAR  = 2'd2;

	localparam logic [63:0] HASH_GOLDEN = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] HASH_MUL_A  = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] HASH_MUL_B  = 64'h94d049bb133111eb;
	localparam int unsigned SHIFT_A = 30;
	localparam int unsigned SHIFT_B = 27;
	localparam int unsigned SHIFT_C = 31;

	typedef struct packed {
		logic [1:0]  action;
		logic [63:0] key;
		logic [8:0]  rank;
	} in_item_t;

	typedef struct packed {
		logic [63:0] sample_key;
		logic [63:0] sample_hash;
		logic        sample_valid;
		logic [9:0]  kept_count;
		logic        complete;
		logic [63:0] theta_value;
		logic [31:0] distinct_count;
	} out_item_t;

	typedef struct packed {
		logic       load;
		logic       note_key;
		logic       mul;
		logic [1:0] mstep;
		logic       round;
		logic       mix;
		logic       set_end;
		logic       rd_last;
		logic       drop_last;
		logic       rd_prev;
		logic       shift;
		logic       place;
		logic       do_clear;
		logic       rd_res;
		logic       emit;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] action;
		logic       dup;
		logic       kept_lt_lim;
		logic       kept_zero;
		logic       new_less;
		logic       idx_zero;
	} dp_stat_t;

endpackage

// ----- rtl/kmv_sketch_builder.sv -----
// top level of the kmv sketch builder: register port, controller and datapath
//
//  channel   | signals                               | transaction
//  ----------+---------------------------------------+------------------------------
//  item in   | start, busy, item                     | start high while busy low
//  result    | done, result                          | done high for one cycle
//  config    | psel penable pwrite paddr pwdata ...  | access phase with pready high
//
// a skipped insert, a read, a clear or the unused action goes from decode straight to
// the result read. a new key is hashed, then walks past the stored samples one entry a
// step (one memory read port) until its slot is found.
// a full sketch first compares the key with its last sample; a key it turns away goes
// straight to the result read.
// reset empties the sketch; the sample memory needs no clearing pass.
// the result cannot be held off; start is taken again in the cycle done shows.
module kmv_sketch_builder #(
	parameter int unsigned CAPACITY = kmv_pkg::CAPACITY_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  kmv_pkg::in_item_t            item,
	output logic                         done,
	output kmv_pkg::out_item_t           result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [kmv_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import kmv_pkg::*;

	logic [9:0] limit_q;
	dp_cmd_t    cmd;
	dp_stat_t   stat;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && paddr == REG_LIMIT_ADDR) begin
			limit_q <= pwdata[9:0];
		end
	end

	assign prdata = (paddr == REG_LIMIT_ADDR) ? {22'd0, limit_q} : 32'd0;

	kmv_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	kmv_datapath #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.sample_limit (limit_q),
		.cmd          (cmd),
		.stat         (stat),
		.done         (done),
		.result       (result)
	);

endmodule

// ----- rtl/kmv_ctrl.sv -----
// controller state machine for the kmv sketch builder
module kmv_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  kmv_pkg::dp_stat_t stat,
	output kmv_pkg::dp_cmd_t  cmd
);
	import kmv_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_MUL    = 4'd2;
	localparam logic [3:0] S_MIX    = 4'd3;
	localparam logic [3:0] S_CMP    = 4'd4;
	localparam logic [3:0] S_SH_RD  = 4'd5;
	localparam logic [3:0] S_SH_CHK = 4'd6;
	localparam logic [3:0] S_RES_RD = 4'd7;
	localparam logic [3:0] S_RES    = 4'd8;

	logic [3:0] state_q, state_d;
	logic [1:0] mstep_q, mstep_d;
	logic       round_q, round_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d   = state_q;
		mstep_d   = mstep_q;
		round_d   = round_q;
		cmd       = '0;
		cmd.mstep = mstep_q;
		cmd.round = round_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				if (stat.action == ACT_INSERT && !stat.dup) begin
					cmd.note_key = 1'b1;
					mstep_d      = 2'd0;
					round_d      = 1'b0;
					state_d      = S_MUL;
				end else begin
					cmd.do_clear = (stat.action == ACT_CLEAR);
					state_d      = S_RES_RD;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				if (mstep_q == 2'd2) begin
					state_d = S_MIX;
				end else begin
					mstep_d = mstep_q + 2'd1;
				end
			end
			S_MIX: begin
				cmd.mix = 1'b1;
				if (!round_q) begin
					round_d = 1'b1;
					mstep_d = 2'd0;
					state_d = S_MUL;
				end else if (stat.kept_lt_lim) begin
					cmd.set_end = 1'b1;
					state_d     = S_SH_RD;
				end else if (stat.kept_zero) begin
					state_d = S_RES_RD;
				end else begin
					cmd.rd_last = 1'b1;
					state_d     = S_CMP;
				end
			end
			S_CMP: begin
				if (stat.new_less) begin
					cmd.drop_last = 1'b1;
					state_d       = S_SH_RD;
				end else begin
					state_d = S_RES_RD;
				end
			end
			S_SH_RD: begin
				if (stat.idx_zero) begin
					cmd.place = 1'b1;
					state_d   = S_RES_RD;
				end else begin
					cmd.rd_prev = 1'b1;
					state_d     = S_SH_CHK;
				end
			end
			S_SH_CHK: begin
				if (stat.new_less) begin
					cmd.shift = 1'b1;
					state_d   = S_SH_RD;
				end else begin
					cmd.place = 1'b1;
					state_d   = S_RES_RD;
				end
			end
			S_RES_RD: begin
				cmd.rd_res = 1'b1;
				state_d    = S_RES;
			end
			S_RES: begin
				cmd.emit = 1'b1;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mstep_q <= 2'd0;
			round_q <= 1'b0;
		end else begin
			state_q <= state_d;
			mstep_q <= mstep_d;
			round_q <= round_d;
		end
	end

endmodule

// ----- rtl/kmv_datapath.sv -----
// datapath: hash unit, counters and the sorted sample memory
module kmv_datapath #(
	parameter int unsigned CAPACITY = kmv_pkg::CAPACITY_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  kmv_pkg::in_item_t item,
	input  logic [9:0]        sample_limit,
	input  kmv_pkg::dp_cmd_t  cmd,
	output kmv_pkg::dp_stat_t stat,
	output logic              done,
	output kmv_pkg::out_item_t result
);
	import kmv_pkg::*;

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned EW = CW + 10;

	logic [127:0] store_q [CAPACITY];
	logic [127:0] rd_a_q, rd_b_q;

	in_item_t    item_q;
	logic [63:0] prev_key_q;
	logic        prev_valid_q;
	logic [31:0] distinct_q;
	logic [CW-1:0] kept_q, idx_q;
	logic [63:0] a_q, acc_q, hash_q;
	logic        done_q;
	out_item_t   result_q;

	logic [EW-1:0] sl_e, vis_e;
	logic [CW-1:0] lim, visible, kept_m1, idx_m1, vis_m1;
	logic [AW-1:0] addr_a;
	logic [AW+8:0] rank_e;
	logic [127:0]  pair;
	logic [63:0]   mconst, t_sum, mprod, acc_add;
	logic [31:0]   mop_a, mop_b;
	logic          comp, rd_ok;

	assign sl_e = EW'(sample_limit);
	assign lim  = (sample_limit == 10'd0 || sl_e > EW'(CAPACITY)) ? CW'(CAPACITY)
		: sl_e[CW-1:0];
	assign visible = (kept_q < lim) ? kept_q : lim;
	assign vis_e   = EW'(visible);
	assign kept_m1 = kept_q - CW'(1);
	assign idx_m1  = idx_q - CW'(1);
	assign vis_m1  = visible - CW'(1);
	assign rank_e  = (AW+9)'(item_q.rank);
	assign pair    = {hash_q, item_q.key};
	assign comp    = distinct_q <= 32'(lim);
	assign rd_ok   = (item_q.action == ACT_READ) && (EW'(item_q.rank) < EW'(visible));

	always_comb begin
		if (cmd.rd_last) begin
			addr_a = kept_m1[AW-1:0];
		end else if (cmd.rd_prev) begin
			addr_a = idx_m1[AW-1:0];
		end else begin
			addr_a = rank_e[AW-1:0];
		end
	end

	assign stat.action      = item_q.action;
	assign stat.dup         = prev_valid_q && (item_q.key == prev_key_q);
	assign stat.kept_lt_lim = kept_q < lim;
	assign stat.kept_zero   = (kept_q == '0);
	assign stat.new_less    = pair < rd_a_q;
	assign stat.idx_zero    = (idx_q == '0);

	// 64x64 low product built from 32x32 partial products over three steps
	assign mconst = cmd.round ? HASH_MUL_B : HASH_MUL_A;
	always_comb begin
		case (cmd.mstep)
			2'd0: begin
				mop_a = a_q[31:0];
				mop_b = mconst[31:0];
			end
			2'd1: begin
				mop_a = a_q[31:0];
				mop_b = mconst[63:32];
			end
			default: begin
				mop_a = a_q[63:32];
				mop_b = mconst[31:0];
			end
		endcase
	end
	assign mprod   = 64'(mop_a) * 64'(mop_b);
	assign acc_add = (cmd.mstep == 2'd0) ? mprod : (acc_q + {mprod[31:0], 32'd0});
	assign t_sum   = item_q.key + HASH_GOLDEN;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (cmd.note_key) begin
			a_q <= t_sum ^ (t_sum >> SHIFT_A);
		end
		if (cmd.mul) begin
			acc_q <= acc_add;
		end
		if (cmd.mix) begin
			if (!cmd.round) begin
				a_q <= acc_q ^ (acc_q >> SHIFT_B);
			end else begin
				hash_q <= acc_q ^ (acc_q >> SHIFT_C);
			end
		end
		if (cmd.rd_last || cmd.rd_prev || cmd.rd_res) begin
			rd_a_q <= store_q[addr_a];
		end
		rd_b_q <= store_q[vis_m1[AW-1:0]];
		if (cmd.shift) begin
			store_q[idx_q[AW-1:0]] <= rd_a_q;
		end else if (cmd.place) begin
			store_q[idx_q[AW-1:0]] <= pair;
		end
		if (cmd.set_end) begin
			idx_q <= kept_q;
		end else if (cmd.drop_last) begin
			idx_q <= kept_m1;
		end else if (cmd.shift) begin
			idx_q <= idx_m1;
		end
		if (cmd.emit) begin
			result_q.sample_key     <= rd_ok ? rd_a_q[63:0] : 64'd0;
			result_q.sample_hash    <= rd_ok ? rd_a_q[127:64] : 64'd0;
			result_q.sample_valid   <= rd_ok;
			result_q.kept_count     <= vis_e[9:0];
			result_q.complete       <= comp;
			result_q.theta_value    <= (comp || visible == '0) ? '1 : rd_b_q[127:64];
			result_q.distinct_count <= distinct_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_key_q   <= '0;
			prev_valid_q <= 1'b0;
			distinct_q   <= '0;
			kept_q       <= '0;
			done_q       <= 1'b0;
		end else begin
			done_q <= cmd.emit;
			if (cmd.do_clear) begin
				prev_key_q   <= '0;
				prev_valid_q <= 1'b0;
				distinct_q   <= '0;
				kept_q       <= '0;
			end
			if (cmd.note_key) begin
				prev_key_q   <= item_q.key;
				prev_valid_q <= 1'b1;
				if (distinct_q != '1) begin
					distinct_q <= distinct_q + 32'd1;
				end
			end
			if (cmd.drop_last) begin
				kept_q <= kept_m1;
			end else if (cmd.place) begin
				kept_q <= kept_q + CW'(1);
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ----- rtl/kmv_checker.sv -----
// port-level checks for the kmv sketch builder, bound to the top level
module kmv_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input kmv_pkg::out_item_t result
);
	import kmv_pkg::*;

	// an accepted transaction keeps the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	// each result shows for a single cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

	a_theta_complete: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.complete |-> result.theta_value == '1)
		else $error("complete sketch reports theta below all ones");

	a_empty_no_sample: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.kept_count == 10'd0 |-> !result.sample_valid)
		else $error("sample returned from an empty sketch");

endmodule

bind kmv_sketch_builder kmv_checker u_kmv_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
